[sv/assert_macros.svh]
// Assertion macros shared by the lexer RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion with synchronous active-low reset disable.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`endif

[sv/slx_pkg.sv]
// Package for the lexer: token type codes, modes and the shared record struct.
// No dependencies.
package slx_pkg;
    localparam int MAX_TOKEN_LEN_DEF = 128;
    localparam int POSITION_BITS_DEF = 16;
    localparam int NKEYS = 22;
    localparam int KEY_CHARS = 14;
    localparam int KEY_BITS = 8 * KEY_CHARS;

    localparam logic [5:0] TYPE_IDENT = 6'd0;
    localparam logic [5:0] TYPE_NUMBER = 6'd1;
    localparam logic [5:0] TYPE_PUNCT0 = 6'd2;
    localparam logic [5:0] TYPE_DIVIDE = 6'd13;
    localparam logic [5:0] TYPE_KEY0 = 6'd18;
    localparam logic [5:0] TYPE_UNKNOWN = 6'd40;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_IDENT = 2'd1;
    localparam logic [1:0] MODE_NUMBER = 2'd2;
    localparam logic [1:0] MODE_COMMENT = 2'd3;

    // One token record as it leaves the front end. The count is added in the back end.
    typedef struct packed {
        logic [5:0]  token_type;
        logic [15:0] start_offset;
        logic [7:0]  token_length;
        logic        overlong;
        logic        stream_done;
        logic        last_of_run;
    } tok_rec_t;

    // Keyword text of keyword n, right-aligned with the last character in the low byte.
    function automatic logic [KEY_BITS-1:0] key_text(input logic [4:0] n);
        logic [KEY_BITS-1:0] t;
        unique case (n)
            5'd0: t = KEY_BITS'("fn");
            5'd1: t = KEY_BITS'("for");
            5'd2: t = KEY_BITS'("if");
            5'd3: t = KEY_BITS'("return");
            5'd4: t = KEY_BITS'("while");
            5'd5: t = KEY_BITS'("sineosc");
            5'd6: t = KEY_BITS'("sawtoothosc");
            5'd7: t = KEY_BITS'("wavetableosc");
            5'd8: t = KEY_BITS'("truesineosc");
            5'd9: t = KEY_BITS'("squareosc");
            5'd10: t = KEY_BITS'("triangleosc");
            5'd11: t = KEY_BITS'("terrainosc");
            5'd12: t = KEY_BITS'("lowpassfilter");
            5'd13: t = KEY_BITS'("highpassfilter");
            5'd14: t = KEY_BITS'("inputa");
            5'd15: t = KEY_BITS'("inputb");
            5'd16: t = KEY_BITS'("inputc");
            5'd17: t = KEY_BITS'("inputd");
            5'd18: t = KEY_BITS'("stepsequencer");
            5'd19: t = KEY_BITS'("random");
            5'd20: t = KEY_BITS'("randomint");
            5'd21: t = KEY_BITS'("linenvelope");
            default: t = '0;
        endcase
        return t;
    endfunction

    // Number of characters in keyword n.
    function automatic logic [3:0] key_len(input logic [4:0] n);
        logic [3:0] l;
        unique case (n)
            5'd0: l = 4'd2;
            5'd1: l = 4'd3;
            5'd2: l = 4'd2;
            5'd3: l = 4'd6;
            5'd4: l = 4'd5;
            5'd5: l = 4'd7;
            5'd6: l = 4'd11;
            5'd7: l = 4'd12;
            5'd8: l = 4'd11;
            5'd9: l = 4'd9;
            5'd10: l = 4'd11;
            5'd11: l = 4'd10;
            5'd12: l = 4'd13;
            5'd13: l = 4'd14;
            5'd14: l = 4'd6;
            5'd15: l = 4'd6;
            5'd16: l = 4'd6;
            5'd17: l = 4'd6;
            5'd18: l = 4'd13;
            5'd19: l = 4'd6;
            5'd20: l = 4'd9;
            5'd21: l = 4'd11;
            default: l = 4'd0;
        endcase
        return l;
    endfunction

    // Keyword text, character k of keyword n; zero past the end.
    function automatic logic [7:0] key_char(input logic [4:0] n, input logic [3:0] k);
        logic [KEY_BITS-1:0] t;
        logic [3:0] l;
        logic [7:0] ch;
        t = key_text(n);
        l = key_len(n);
        ch = 8'd0;
        if (k < l) begin
            ch = t[8 * (int'(l) - 1 - int'(k)) +: 8];
        end
        return ch;
    endfunction

    // Punctuator code, or unknown.
    function automatic logic [5:0] punct_type(input logic [7:0] c);
        logic [5:0] t;
        unique case (c)
            8'h3B: t = TYPE_PUNCT0 + 6'd0;
            8'h3D: t = TYPE_PUNCT0 + 6'd1;
            8'h28: t = TYPE_PUNCT0 + 6'd2;
            8'h29: t = TYPE_PUNCT0 + 6'd3;
            8'h7B: t = TYPE_PUNCT0 + 6'd4;
            8'h7D: t = TYPE_PUNCT0 + 6'd5;
            8'h5B: t = TYPE_PUNCT0 + 6'd6;
            8'h5D: t = TYPE_PUNCT0 + 6'd7;
            8'h2B: t = TYPE_PUNCT0 + 6'd8;
            8'h2D: t = TYPE_PUNCT0 + 6'd9;
            8'h2A: t = TYPE_PUNCT0 + 6'd10;
            8'h2F: t = TYPE_DIVIDE;
            8'h3E: t = TYPE_PUNCT0 + 6'd12;
            8'h3C: t = TYPE_PUNCT0 + 6'd13;
            8'h2C: t = TYPE_PUNCT0 + 6'd14;
            8'h24: t = TYPE_PUNCT0 + 6'd15;
            default: t = TYPE_UNKNOWN;
        endcase
        return t;
    endfunction
endpackage

[sv/slx_front.sv]
// Front end of the lexer: classifies each byte and builds up to two token records.
// Depends on slx_pkg and assert_macros.svh.
module slx_front #(
    parameter int MAX_TOKEN_LEN = slx_pkg::MAX_TOKEN_LEN_DEF,
    parameter int POSITION_BITS = slx_pkg::POSITION_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  logic             in_end,
    input  logic [7:0]       in_byte,
    input  logic             q_room,
    output logic             in_ready,
    output logic [1:0]       rec_count,
    output slx_pkg::tok_rec_t rec0,
    output slx_pkg::tok_rec_t rec1
);
    import slx_pkg::*;

    logic [1:0]               mode_reg, mode_next;
    logic                     slash_reg, slash_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [7:0]               len_reg, len_next;
    logic                     over_reg, over_next;
    logic [NKEYS-1:0]         alive_reg, alive_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;

    logic letter, digit, sep;
    logic [5:0] kw_type;
    tok_rec_t flush_rec, div_rec, end_rec;

    assign in_ready = q_room;
    assign letter = (in_byte >= 8'h61 && in_byte <= 8'h7A) ||
                    (in_byte >= 8'h41 && in_byte <= 8'h5A);
    assign digit = in_byte >= 8'h30 && in_byte <= 8'h39;
    assign sep = in_byte == 8'h20 || in_byte == 8'h09 || in_byte == 8'h0D ||
                 in_byte == 8'h0A;

    // Type of the held token when it is flushed.
    always_comb begin
        kw_type = TYPE_IDENT;
        if (!over_reg) begin
            for (int k = 0; k < NKEYS; k++) begin
                if (alive_reg[k] && {4'd0, key_len(5'(k))} == len_reg) begin
                    kw_type = TYPE_KEY0 + 6'(k);
                end
            end
        end
        flush_rec = '{token_type: (mode_reg == MODE_IDENT) ? kw_type : TYPE_NUMBER,
                      start_offset: 16'(start_reg), token_length: len_reg,
                      overlong: over_reg, stream_done: 1'b0, last_of_run: 1'b0};
        div_rec = '{token_type: TYPE_DIVIDE, start_offset: 16'(start_reg),
                    token_length: 8'd1, overlong: 1'b0, stream_done: 1'b0,
                    last_of_run: 1'b0};
        end_rec = '{token_type: TYPE_IDENT, start_offset: 16'(pos_reg),
                    token_length: 8'd0, overlong: 1'b0, stream_done: 1'b1,
                    last_of_run: 1'b1};
    end

    // Per-byte lexing step.
    always_comb begin
        logic ext, start, cont;
        logic [7:0] base_len;
        tok_rec_t r0, r1;
        logic [1:0] n;
        mode_next = mode_reg;
        slash_next = slash_reg;
        start_next = start_reg;
        len_next = len_reg;
        over_next = over_reg;
        alive_next = alive_reg;
        pos_next = pos_reg;
        ext = 1'b0;
        start = 1'b0;
        cont = 1'b0;
        base_len = len_reg;
        r0 = flush_rec;
        r1 = flush_rec;
        n = 2'd0;
        if (in_end) begin
            if (slash_reg) begin
                r0 = div_rec;
                n = 2'd1;
            end else if (mode_reg == MODE_IDENT || mode_reg == MODE_NUMBER) begin
                r0 = flush_rec;
                n = 2'd1;
            end
            if (n == 2'd1) begin
                r1 = end_rec;
                n = 2'd2;
            end else begin
                r0 = end_rec;
                n = 2'd1;
            end
            mode_next = MODE_IDLE;
            slash_next = 1'b0;
            start_next = '0;
            len_next = 8'd0;
            over_next = 1'b0;
            alive_next = '1;
            pos_next = '0;
        end else begin
            pos_next = pos_reg + POSITION_BITS'(1);
            if (mode_reg == MODE_COMMENT) begin
                if (in_byte == 8'h0A) begin
                    mode_next = MODE_IDLE;
                end
                cont = 1'b1;
            end else if (slash_reg && in_byte == 8'h2F) begin
                slash_next = 1'b0;
                mode_next = MODE_COMMENT;
                cont = 1'b1;
            end else if (mode_reg == MODE_IDENT && (letter || digit || in_byte == 8'h23)) begin
                ext = 1'b1;
                cont = 1'b1;
            end else if (mode_reg == MODE_NUMBER && (digit || in_byte == 8'h2E)) begin
                ext = 1'b1;
                cont = 1'b1;
            end
            if (!cont) begin
                // Held slash or held token, then what this byte yields.
                if (slash_reg) begin
                    r0 = div_rec;
                    n = 2'd1;
                    slash_next = 1'b0;
                end else if (mode_reg == MODE_IDENT || mode_reg == MODE_NUMBER) begin
                    r0 = flush_rec;
                    n = 2'd1;
                    mode_next = MODE_IDLE;
                end
                if (sep) begin
                end else if (in_byte == 8'h2F) begin
                    slash_next = 1'b1;
                    start_next = pos_reg;
                end else if (letter || digit) begin
                    start = 1'b1;
                    ext = 1'b1;
                    mode_next = letter ? MODE_IDENT : MODE_NUMBER;
                    start_next = pos_reg;
                    over_next = 1'b0;
                    base_len = 8'd0;
                end else begin
                    if (n == 2'd1) begin
                        r1 = '{token_type: punct_type(in_byte),
                               start_offset: 16'(pos_reg), token_length: 8'd1,
                               overlong: 1'b0, stream_done: 1'b0, last_of_run: 1'b0};
                    end else begin
                        r0 = '{token_type: punct_type(in_byte),
                               start_offset: 16'(pos_reg), token_length: 8'd1,
                               overlong: 1'b0, stream_done: 1'b0, last_of_run: 1'b0};
                    end
                    n = n + 2'd1;
                end
            end
            if (ext) begin
                if ((start && letter) || (!start && mode_reg == MODE_IDENT)) begin
                    for (int k = 0; k < NKEYS; k++) begin
                        if ({4'd0, key_len(5'(k))} <= base_len ||
                            key_char(5'(k), base_len[3:0]) != in_byte) begin
                            alive_next[k] = 1'b0;
                        end else begin
                            alive_next[k] = start ? 1'b1 : alive_reg[k];
                        end
                    end
                end
                if (start) begin
                    len_next = 8'd1;
                end else if (len_reg < 8'(MAX_TOKEN_LEN)) begin
                    len_next = len_reg + 8'd1;
                end else begin
                    over_next = 1'b1;
                end
            end
        end
        if (n == 2'd2) begin
            r1.last_of_run = 1'b1;
        end else if (n == 2'd1) begin
            r0.last_of_run = 1'b1;
        end
        rec0 = r0;
        rec1 = r1;
        rec_count = (in_valid && q_room) ? n : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            slash_reg <= 1'b0;
            start_reg <= '0;
            len_reg <= 8'd0;
            over_reg <= 1'b0;
            alive_reg <= '1;
            pos_reg <= '0;
        end else if (in_valid && q_room) begin
            mode_reg <= mode_next;
            slash_reg <= slash_next;
            start_reg <= start_next;
            len_reg <= len_next;
            over_reg <= over_next;
            alive_reg <= alive_next;
            pos_reg <= pos_next;
        end
    end

`include "assert_macros.svh"
    `ASSERT_CLK(a_len_cap, aclk, aresetn, len_reg <= 8'(MAX_TOKEN_LEN), "token length above cap")
    `ASSERT_CLK(a_slash_idle, aclk, aresetn, !slash_reg || mode_reg == MODE_IDLE, "slash held mid-token")
    `ASSERT_CLK(a_over_len, aclk, aresetn, !over_reg || len_reg == 8'(MAX_TOKEN_LEN), "overlong below cap")
endmodule

[sv/slx_back.sv]
// Back end: a small record queue, token counting and the output port.
// Depends on slx_pkg and assert_macros.svh.
module slx_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        rec_count,
    input  slx_pkg::tok_rec_t rec0,
    input  slx_pkg::tok_rec_t rec1,
    output logic              q_room,
    output logic              out_valid,
    input  logic              out_ready,
    output slx_pkg::tok_rec_t out_rec,
    output logic [15:0]       out_count
);
    import slx_pkg::*;

    localparam int DEPTH = 4;

    tok_rec_t   mem [DEPTH];
    logic [1:0] wr_reg, rd_reg;
    logic [2:0] fill_reg;
    logic [15:0] cnt_reg;
    logic pop;
    logic [15:0] cnt_now;

    // Room means two records still fit, the most the front pushes for one byte.
    assign q_room = fill_reg <= 3'd2;
    assign out_valid = fill_reg != 3'd0;
    assign out_rec = mem[rd_reg];
    assign pop = out_valid && out_ready;
    assign out_count = cnt_now;

    // Count including this record; the final record reports without adding.
    always_comb begin
        cnt_now = cnt_reg;
        if (!out_rec.stream_done && cnt_reg != 16'hFFFF) begin
            cnt_now = cnt_reg + 16'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rec_count != 2'd0) begin
            mem[wr_reg] <= rec0;
        end
        if (rec_count == 2'd2) begin
            mem[wr_reg + 2'd1] <= rec1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= 2'd0;
            rd_reg <= 2'd0;
            fill_reg <= 3'd0;
            cnt_reg <= 16'd0;
        end else begin
            wr_reg <= wr_reg + rec_count;
            rd_reg <= rd_reg + {1'b0, pop};
            fill_reg <= fill_reg + {1'b0, rec_count} - {2'b0, pop};
            if (pop) begin
                cnt_reg <= out_rec.stream_done ? 16'd0 : cnt_now;
            end
        end
    end

`include "assert_macros.svh"
    `ASSERT_CLK(a_fill_max, aclk, aresetn, fill_reg <= 3'(DEPTH), "queue overflow")
    `ASSERT_CLK(a_no_push_full, aclk, aresetn, rec_count == 2'd0 || q_room, "push without room")
endmodule

[sv/script_lexer_with_keywords_core.sv]
// Streaming lexer: one text byte per cycle in while s_tready is high, token
// records out, with keyword reclassing, line comments and an end-of-text summary
// record. The front end takes a byte every cycle while the four-entry record queue
// has room for two records; the output port drains one record per cycle while
// m_tready is high.
// Depends on slx_pkg, slx_front and slx_back.
module script_lexer_with_keywords_core #(
    parameter int MAX_TOKEN_LEN = slx_pkg::MAX_TOKEN_LEN_DEF,
    parameter int POSITION_BITS = slx_pkg::POSITION_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_byte
    input  logic        s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // token_type, start_offset, token_length, overlong,
                                   // stream_done, token_count
    output logic        m_tlast    // last_of_run
);
    import slx_pkg::*;

    logic [1:0] rec_count;
    logic q_room;
    tok_rec_t rec0, rec1, out_rec;
    logic [15:0] out_count;

    slx_front #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN), .POSITION_BITS(POSITION_BITS)) u_front (
        .aclk, .aresetn, .in_valid(s_tvalid), .in_end(s_tuser), .in_byte(s_tdata),
        .q_room, .in_ready(s_tready), .rec_count, .rec0, .rec1
    );

    slx_back u_back (
        .aclk, .aresetn, .rec_count, .rec0, .rec1, .q_room,
        .out_valid(m_tvalid), .out_ready(m_tready), .out_rec, .out_count
    );

    assign m_tdata = {out_count, out_rec.stream_done, out_rec.overlong,
                      out_rec.token_length, out_rec.start_offset, out_rec.token_type};
    assign m_tlast = out_rec.last_of_run;
endmodule
